[hw/rtl/hwb_pkg.sv]
package hwb_pkg;

    localparam int SYMBOL_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int DIV_STEPS       = 16;
    localparam int DIV_CNT_BITS    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        KIND_QUERY = 3'd0,
        KIND_INC   = 3'd1,
        KIND_DEC   = 3'd2,
        KIND_SET   = 3'd3,
        KIND_ERASE = 3'd4,
        KIND_CLEAR = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_SWEEP_RST,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_SWEEP_OP,
        ST_SCAN,
        ST_SCAN_END,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic read_bin;
        logic update;
        logic sweep;
        logic scan;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic go_scan;
        logic go_sweep;
        logic sweep_last;
        logic scan_last;
        logic div_last;
    } stat_t;

endpackage

[hw/rtl/hwb_ctrl.sv]
module hwb_ctrl import hwb_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP_RST;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_SWEEP_RST: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read_bin = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                if (stat.go_scan)       state_next = ST_SCAN;
                else if (stat.go_sweep) state_next = ST_SWEEP_OP;
                else                    state_next = ST_PREP;
            end
            ST_SWEEP_OP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) state_next = ST_PREP;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) state_next = ST_SCAN_END;
            end
            ST_SCAN_END: state_next = ST_PREP;
            ST_PREP: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

[hw/rtl/hwb_datapath.sv]
module hwb_datapath import hwb_pkg::*; #(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [2:0]   in_kind,
    input  logic [39:0]  in_data,
    input  cmd_t         cmd,
    output stat_t        stat,
    output logic [103:0] out_data
);

    localparam int NSYM = 1 << SYMBOL_BITS;
    localparam int SB   = SYMBOL_BITS;
    localparam int CB   = COUNT_BITS;

    logic [CB-1:0] mem [NSYM];
    logic [CB-1:0] rdata_reg;
    logic          we;
    logic [SB-1:0] wa, ra;
    logic [CB-1:0] wd;

    kind_t         kind_reg;
    logic [SB-1:0] sym_reg;
    logic [CB-1:0] c_reg;
    logic [CB-1:0] sum_reg, sum_next;
    logic [SB-1:0] low_reg, low_next, high_reg, high_next;
    logic [CB-1:0] bin_reg, bin_next;
    logic          ovf_reg, ovf_next;
    logic [SB-1:0] addr_reg;
    logic          sc_v_reg, found_reg;
    logic [SB-1:0] sc_idx_reg;
    logic [CB-1:0] r_reg, q_sh;
    logic [15:0]   q_reg;
    logic [DIV_CNT_BITS-1:0] dcnt_reg;
    logic          zden_reg, sat_reg;
    logic          wr_bin, clr_path;
    logic [CB:0]   set_tot, two_r;
    logic [CB-1:0] rest;
    logic          was_empty;

    // bin store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        rdata_reg <= mem[ra];
    end

    assign ra = cmd.read_bin ? sym_reg : addr_reg;
    assign wa = cmd.sweep ? addr_reg : sym_reg;
    assign we = cmd.sweep || (cmd.update && wr_bin);
    assign wd = cmd.sweep ? '0 : bin_next;

    assign was_empty = (sum_reg == '0);
    assign rest      = sum_reg - rdata_reg;
    assign set_tot   = {1'b0, rest} + {1'b0, c_reg};

    always_comb begin
        sum_next  = sum_reg;
        low_next  = low_reg;
        high_next = high_reg;
        bin_next  = rdata_reg;
        ovf_next  = 1'b0;
        wr_bin    = 1'b0;
        clr_path  = 1'b0;
        stat.go_sweep   = 1'b0;
        stat.sweep_last = &addr_reg;
        stat.scan_last  = &addr_reg;
        stat.div_last   = (dcnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1));
        case (kind_reg)
            KIND_INC: begin
                if (&sum_reg) ovf_next = 1'b1;
                else begin
                    bin_next = rdata_reg + 1'b1;
                    sum_next = sum_reg + 1'b1;
                    wr_bin   = 1'b1;
                end
            end
            KIND_DEC: begin
                if (rdata_reg == CB'(1)) clr_path = 1'b1;
                else if (rdata_reg != '0) begin
                    bin_next = rdata_reg - 1'b1;
                    sum_next = sum_reg - 1'b1;
                    wr_bin   = 1'b1;
                end
            end
            KIND_SET: begin
                if (c_reg == '0) clr_path = 1'b1;
                else if (set_tot[CB]) ovf_next = 1'b1;
                else begin
                    bin_next = c_reg;
                    sum_next = set_tot[CB-1:0];
                    wr_bin   = 1'b1;
                end
            end
            KIND_ERASE: clr_path = 1'b1;
            KIND_CLEAR: begin
                sum_next  = '0;
                low_next  = '0;
                high_next = '0;
                bin_next  = '0;
                stat.go_sweep = 1'b1;
            end
            default: ;
        endcase
        // widen bounds on a successful insert
        if (wr_bin && (kind_reg == KIND_INC || kind_reg == KIND_SET)) begin
            if (was_empty) begin
                low_next  = sym_reg;
                high_next = sym_reg;
            end else begin
                if (sym_reg < low_reg)  low_next  = sym_reg;
                if (sym_reg > high_reg) high_next = sym_reg;
            end
        end
        stat.go_scan = 1'b0;
        if (clr_path && rdata_reg != '0) begin
            sum_next  = sum_reg - rdata_reg;
            bin_next  = '0;
            wr_bin    = 1'b1;
            low_next  = '0;
            high_next = '0;
            stat.go_scan = 1'b1;
        end
    end

    assign two_r = {r_reg, 1'b0};
    assign q_sh  = '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            addr_reg  <= '0;
            sc_v_reg  <= 1'b0;
            found_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else begin
            sc_v_reg <= cmd.scan;
            if (cmd.load_in) begin
                kind_reg <= kind_t'(in_kind);
                sym_reg  <= SB'(in_data[7:0]);
                c_reg    <= CB'(in_data[39:8]);
            end
            if (cmd.update) begin
                sum_reg   <= sum_next;
                low_reg   <= low_next;
                high_reg  <= high_next;
                bin_reg   <= bin_next;
                ovf_reg   <= ovf_next;
                addr_reg  <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.sweep || cmd.scan) addr_reg <= addr_reg + 1'b1;
            if (cmd.scan) sc_idx_reg <= addr_reg;
            // rescan: first nonzero gives low, last nonzero gives high
            if (sc_v_reg && rdata_reg != '0) begin
                if (!found_reg) low_reg <= sc_idx_reg;
                found_reg <= 1'b1;
                high_reg  <= sc_idx_reg;
            end
            if (cmd.div_init) begin
                r_reg    <= bin_reg;
                q_reg    <= '0;
                dcnt_reg <= '0;
                zden_reg <= (sum_reg == '0);
                sat_reg  <= (bin_reg >= sum_reg);
            end
            if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg + 1'b1;
                if (two_r >= {1'b0, sum_reg}) begin
                    r_reg <= CB'(two_r - {1'b0, sum_reg});
                    q_reg <= {q_reg[14:0], 1'b1};
                end else begin
                    r_reg <= two_r[CB-1:0] | q_sh;
                    q_reg <= {q_reg[14:0], 1'b0};
                end
            end
            if (cmd.out_load) begin
                out_data[31:0]   <= 32'(bin_reg);
                out_data[63:32]  <= 32'(sum_reg);
                out_data[71:64]  <= 8'(low_reg);
                out_data[79:72]  <= 8'(high_reg);
                out_data[80]     <= zden_reg;
                out_data[96:81]  <= zden_reg ? 16'h0000 : (sat_reg ? 16'hFFFF : q_reg);
                out_data[97]     <= ovf_reg;
                out_data[103:98] <= '0;
            end
        end
    end

endmodule

[hw/rtl/histogram_with_bounds_top.sv]
// channel | dir | tdata fields (low bit up)                          | tuser
// s_      | in  | symbol[7:0], new_count[39:8]                       | kind[2:0]
// m_      | out | bin_count[31:0], total[63:32], lowest[71:64],      | -
//         |     | highest[79:72], empty_res[80], probability[96:81], |
//         |     | overflow[97], zero pad to 104 bits                 |
// one transaction at a time; after the accept a plain operation runs through
// read, update, prep, 16 restoring division steps and the output load
// a bin dropping to zero adds a rescan over the bin ram
// clear adds a zero sweep over the bin ram; after reset the same sweep runs before s_tready
// a result waiting on m_tready holds; the next transaction is taken meanwhile
module histogram_with_bounds_top import hwb_pkg::*; #(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // symbol, new_count
    input  logic [2:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // bin_count, total, lowest, highest, empty_res,
                                    // probability, overflow
);

    // command and status between controller and datapath
    cmd_t  cmd;
    stat_t stat;

    hwb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // bin ram, total, bounds, divider and output register
    hwb_datapath #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_kind  (s_tuser),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // an accepted transaction closes the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");

    // a result never appears the cycle after an accept
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result too early");

    // an empty table reports zero total, zero share and zero bounds
    a_empty_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[80]) |-> (m_tdata[63:32] == 32'd0 && m_tdata[96:81] == 16'd0
            && m_tdata[71:64] == 8'd0 && m_tdata[79:72] == 8'd0))
        else $error("empty result inconsistent");
`endif

endmodule

[tb/tb_histogram_with_bounds_top.sv]
`timescale 1ns / 1ps

module tb_histogram_with_bounds_top;
    import hwb_pkg::*;

    // result record, filled field by field from m_tdata
    typedef struct packed {
        logic [31:0] bin_count;
        logic [31:0] total;
        logic [7:0]  lowest;
        logic [7:0]  highest;
        logic        empty_res;
        logic [15:0] probability;
        logic        overflow;
    } hist_result_t;

    localparam int NUM_SYMBOLS = 256;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;     // symbol[7:0], new_count[39:8]
    logic [2:0]   s_tuser;     // kind[2:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;     // bin_count, total, lowest, highest, empty_res,
                               // probability, overflow, zero pad

    // shadow copy of the count table
    logic [31:0] bin_shadow [NUM_SYMBOLS];
    logic [31:0] sum_shadow;
    logic [7:0]  low_shadow;
    logic [7:0]  high_shadow;

    hist_result_t expected_results [$];
    int  mismatch_count;
    int  items_sent;
    bit  hold_off_req;       // long receiver hold-off requested
    bit  rx_random_stall;    // receiver stalls at random when set
    bit  tx_random_gap;      // sender idles at random when set

    histogram_with_bounds_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // find the bounds again after a bin drops to zero
    function automatic void rescan_bounds();
        bit found;
        found = 1'b0;
        low_shadow = '0;
        high_shadow = '0;
        for (int i = 0; i < NUM_SYMBOLS; i++) begin
            if (bin_shadow[i] != 0) begin
                if (!found) begin
                    low_shadow = i[7:0];
                    found = 1'b1;
                end
                high_shadow = i[7:0];
            end
        end
    endfunction

    function automatic void clear_bin(logic [7:0] sym);
        if (bin_shadow[sym] == 0)
            return;
        sum_shadow = sum_shadow - bin_shadow[sym];
        bin_shadow[sym] = '0;
        rescan_bounds();
    endfunction

    function automatic void widen_bounds(logic [7:0] sym, bit was_empty);
        if (was_empty) begin
            low_shadow = sym;
            high_shadow = sym;
        end else begin
            if (sym < low_shadow)
                low_shadow = sym;
            if (sym > high_shadow)
                high_shadow = sym;
        end
    endfunction

    // count over total as a q0.16 fraction, restoring division
    function automatic logic [15:0] share_q16(logic [31:0] num, logic [31:0] den);
        logic [15:0] q;
        logic [32:0] r;
        if (den == 0)
            return '0;
        if (num >= den)
            return 16'hffff;
        q = '0;
        r = {1'b0, num};
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic hist_result_t apply_operation(logic [2:0] kind, logic [7:0] sym,
                                                     logic [31:0] cnt);
        hist_result_t res;
        bit ovf;
        bit was_empty;
        logic [31:0] rest;
        ovf = 1'b0;
        was_empty = (sum_shadow == 0);
        case (kind)
            KIND_INC: begin
                if (sum_shadow == 32'hffff_ffff) begin
                    ovf = 1'b1;
                end else begin
                    bin_shadow[sym] = bin_shadow[sym] + 1;
                    sum_shadow = sum_shadow + 1;
                    widen_bounds(sym, was_empty);
                end
            end
            KIND_DEC: begin
                if (bin_shadow[sym] == 1) begin
                    clear_bin(sym);
                end else if (bin_shadow[sym] != 0) begin
                    bin_shadow[sym] = bin_shadow[sym] - 1;
                    sum_shadow = sum_shadow - 1;
                end
            end
            KIND_SET: begin
                if (cnt == 0) begin
                    clear_bin(sym);
                end else begin
                    rest = sum_shadow - bin_shadow[sym];
                    if (cnt > 32'hffff_ffff - rest) begin
                        ovf = 1'b1;
                    end else begin
                        bin_shadow[sym] = cnt;
                        sum_shadow = rest + cnt;
                        widen_bounds(sym, was_empty);
                    end
                end
            end
            KIND_ERASE: clear_bin(sym);
            KIND_CLEAR: begin
                foreach (bin_shadow[i]) bin_shadow[i] = '0;
                sum_shadow = '0;
                low_shadow = '0;
                high_shadow = '0;
            end
            default: ;
        endcase
        res.bin_count = bin_shadow[sym];
        res.total = sum_shadow;
        res.lowest = low_shadow;
        res.highest = high_shadow;
        res.empty_res = (sum_shadow == 0);
        res.probability = share_q16(bin_shadow[sym], sum_shadow);
        res.overflow = ovf;
        return res;
    endfunction

    // send one transaction; the prediction is made at the accepting edge
    task automatic send_op(logic [2:0] kind, logic [7:0] sym, logic [31:0] cnt);
        int gap;
        gap = tx_random_gap ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {cnt, sym};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(apply_operation(kind, sym, cnt));
        items_sent++;
        @(negedge aclk);
    endtask

    // wait until every outstanding result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    // receiver ready: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            stall = rx_random_stall ? $urandom_range(0, 19) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    initial begin
        hist_result_t want;
        hist_result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.bin_count   = m_tdata[31:0];
                got.total       = m_tdata[63:32];
                got.lowest      = m_tdata[71:64];
                got.highest     = m_tdata[79:72];
                got.empty_res   = m_tdata[80];
                got.probability = m_tdata[96:81];
                got.overflow    = m_tdata[97];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transaction: %h", m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp cnt=%h tot=%h lo=%h hi=%h e=%b p=%h o=%b,",
                                     want.bin_count, want.total, want.lowest, want.highest,
                                     want.empty_res, want.probability, want.overflow,
                                     " got cnt=%h tot=%h lo=%h hi=%h e=%b p=%h o=%b",
                                     got.bin_count, got.total, got.lowest, got.highest,
                                     got.empty_res, got.probability, got.overflow);
                    end
                end
            end
        end
    end

    // extremes of symbol and count, every kind
    task automatic test_directed();
        send_op(KIND_QUERY, 8'd0, 32'd0);
        send_op(KIND_DEC, 8'd5, 32'd0);          // decrement on empty bin
        send_op(KIND_ERASE, 8'd5, 32'd0);        // erase on empty bin
        send_op(KIND_INC, 8'd200, 32'd0);        // first insert sets both bounds
        send_op(KIND_INC, 8'd255, 32'hffff_ffff);
        send_op(KIND_INC, 8'd0, 32'd0);
        send_op(KIND_SET, 8'd17, 32'd1000);
        send_op(KIND_QUERY, 8'd17, 32'd0);
        send_op(KIND_DEC, 8'd255, 32'd0);        // decrement from one, rescan
        send_op(KIND_ERASE, 8'd0, 32'd0);
        send_op(KIND_SET, 8'd17, 32'd0);         // set to zero erases
        send_op(KIND_ERASE, 8'd200, 32'd0);      // last entry gone, bounds 0
        send_op(KIND_SET, 8'd128, 32'hffff_fffe);
        send_op(KIND_INC, 8'd1, 32'd0);          // total reaches max
        send_op(KIND_INC, 8'd2, 32'd0);          // overflow flagged
        send_op(KIND_SET, 8'd3, 32'd5);          // set overflow
        send_op(KIND_SET, 8'd128, 32'hffff_ffff); // replaces own bin, overflows
        send_op(KIND_QUERY, 8'd1, 32'd0);
        send_op(3'd6, 8'd128, 32'h5555_aaaa);    // unused kinds act as query
        send_op(3'd7, 8'd1, 32'haaaa_5555);
        send_op(KIND_CLEAR, 8'd9, 32'd0);
        send_op(KIND_QUERY, 8'd128, 32'd0);
    endtask

    // receiver blocks long enough for the block to back up its input
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        for (int i = 0; i < 8; i++)
            send_op(KIND_INC, 8'($urandom_range(0, 255)), $urandom);
        wait_drained();                          // sender pauses until all results are in
    endtask

    task automatic random_op();
        int pick;
        logic [7:0] sym;
        logic [31:0] cnt;
        pick = $urandom_range(0, 99);
        // most traffic in a small window so bins get reused and emptied
        sym = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(60, 75));
        case ($urandom_range(0, 3))
            0: cnt = $urandom;
            1: cnt = $urandom_range(1, 4);
            2: cnt = 32'hffff_ffff - $urandom_range(0, 3);
            default: cnt = 32'($urandom_range(0, 1000));
        endcase
        if (pick < 35)      send_op(KIND_INC, sym, cnt);
        else if (pick < 60) send_op(KIND_DEC, sym, cnt);
        else if (pick < 72) send_op(KIND_SET, sym, cnt);
        else if (pick < 82) send_op(KIND_ERASE, sym, cnt);
        else if (pick < 84) send_op(KIND_CLEAR, sym, cnt);
        else if (pick < 86) send_op(3'($urandom_range(6, 7)), sym, cnt);
        else                send_op(KIND_QUERY, sym, cnt);
    endtask

    task automatic test_random();
        for (int i = 0; i < 1000; i++) begin
            // every 200 items, pick at random whether sender idling and receiver stalls are on
            if (i % 200 == 0) begin
                tx_random_gap = ($urandom_range(0, 3) != 0);
                rx_random_stall = ($urandom_range(0, 3) != 0);
            end
            random_op();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        mismatch_count = 0;
        items_sent = 0;
        hold_off_req = 1'b0;
        rx_random_stall = 1'b1;
        tx_random_gap = 1'b1;
        foreach (bin_shadow[i]) bin_shadow[i] = '0;
        sum_shadow = '0;
        low_shadow = '0;
        high_shadow = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (600) @(negedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // worst case: 1030 items, each with its rescan or sweep work plus gaps and stalls
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/hwb_pkg.sv
hw/rtl/hwb_ctrl.sv
hw/rtl/hwb_datapath.sv
hw/rtl/histogram_with_bounds_top.sv
tb/tb_histogram_with_bounds_top.sv
